@@ sv/jet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, constants and helpers of the Julia escape-time unit.
// ----------------------------------------------------------------------------
package jet_pkg;

  // Fixed-point format of z and c
  localparam int WORD_WIDTH    = 32;
  localparam int FRACTION_BITS = 28;
  localparam int PROD_WIDTH    = 2 * WORD_WIDTH;

  // Iteration counter and limit register
  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_WIDTH = 16;

  // Number of cells in the iteration ring
  localparam int NUM_CELLS = 4;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_C_REAL = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_C_IMAG = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LIMIT  = 2'd2;

  // Register reset values
  localparam logic [WORD_WIDTH-1:0]  C_REAL_RESET = 32'd99321119;
  localparam logic [WORD_WIDTH-1:0]  C_IMAG_RESET = 32'd26843546;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET  = 16'd500;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic [COUNT_WIDTH-1:0]       count_t;
  typedef logic [LIMIT_WIDTH-1:0]       limit_t;

  localparam count_t COUNT_MAX = '1;

  // Escape threshold 4.0, compared against the sum of the two squares
  localparam prod_t ESCAPE_MAG = prod_t'(64'sd4 <<< FRACTION_BITS);

  localparam prod_t WORD_HI = prod_t'({1'b0, {(WORD_WIDTH-1){1'b1}}});
  localparam prod_t WORD_LO = -WORD_HI - prod_t'(1);

  // Point in flight between cells
  typedef struct packed {
    logic   valid;
    word_t  zr;
    word_t  zi;
    count_t count;
  } token_t;

  // Finished pixel leaving a cell
  typedef struct packed {
    logic   valid;
    count_t count;
  } result_t;

  // Saturate a wide sum to the signed word range
  function automatic word_t sat_word(input prod_t x);
    word_t r;
    if (x > WORD_HI) begin
      r = word_t'(WORD_HI[WORD_WIDTH-1:0]);
    end else if (x < WORD_LO) begin
      r = word_t'(WORD_LO[WORD_WIDTH-1:0]);
    end else begin
      r = x[WORD_WIDTH-1:0];
    end
    return r;
  endfunction

  // Clamp the limit register to what the counter can hold
  function automatic count_t clamp_limit(input limit_t lim);
    logic [32:0] lw;
    logic [32:0] mx;
    lw = 33'(lim);
    mx = 33'(COUNT_MAX);
    return (lw > mx) ? COUNT_MAX : lw[COUNT_WIDTH-1:0];
  endfunction

endpackage

@@ sv/jet_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_cell
// One iteration z = z*z + c in two stages: products, then sum and escape test.
// ----------------------------------------------------------------------------
module jet_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  jet_pkg::word_t  c_real_i,
  input  jet_pkg::word_t  c_imag_i,
  input  jet_pkg::count_t limit_i,
  input  jet_pkg::token_t tok_i,
  output jet_pkg::token_t tok_o,
  output jet_pkg::result_t res_o
);

  // Stage A: products
  logic            a_valid_q;
  jet_pkg::count_t a_count_q;
  jet_pkg::prod_t  prr_q, pii_q, pri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_count_q <= tok_i.count;
      prr_q     <= tok_i.zr * tok_i.zr;
      pii_q     <= tok_i.zi * tok_i.zi;
      pri_q     <= tok_i.zr * tok_i.zi;
    end
  end

  // Stage B: floor shifts, escape test, next z
  jet_pkg::prod_t rr, ii, ri, mag;
  logic           done;
  jet_pkg::token_t tok_d;
  jet_pkg::result_t res_d;

  always_comb begin
    rr   = prr_q >>> jet_pkg::FRACTION_BITS;
    ii   = pii_q >>> jet_pkg::FRACTION_BITS;
    ri   = pri_q >>> (jet_pkg::FRACTION_BITS - 1);
    mag  = rr + ii;
    done = (a_count_q >= limit_i) || (mag > jet_pkg::ESCAPE_MAG);

    tok_d.valid = a_valid_q && !done;
    tok_d.zr    = jet_pkg::sat_word(rr - ii + jet_pkg::prod_t'(c_real_i));
    tok_d.zi    = jet_pkg::sat_word(ri + jet_pkg::prod_t'(c_imag_i));
    tok_d.count = a_count_q + jet_pkg::count_t'(1);

    res_d.valid = a_valid_q && !done ? 1'b0 : a_valid_q;
    res_d.count = a_count_q;
  end

  jet_pkg::token_t  tok_q;
  jet_pkg::result_t res_q;

  // Stage B output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      res_q <= '0;
    end else if (en_i) begin
      tok_q <= tok_d;
      res_q <= res_d;
    end
  end

  assign tok_o = tok_q;
  assign res_o = res_q;

endmodule

@@ sv/julia_escape_time_unit.sv @@
`timescale 1ns / 1ps
// Each iteration of a pixel passes through the two stages of one ring cell,
// products and then sum and escape test, and the pixel moves on cell by cell.
// Throughput: one pixel at a time; the input is not ready again until the
// result of the pixel in flight has been loaded into the output register.
// Reset: asynchronous, active low; c and the limit return to 0.37, 0.1, 500,
// the ring and the output register empty.
// ----------------------------------------------------------------------------
// julia_escape_time_unit
// Julia set escape-time counter over a ring of iteration cells.
// ----------------------------------------------------------------------------
module julia_escape_time_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [jet_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [jet_pkg::WORD_WIDTH-1:0]      cfg_data_i,
  // Start point stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] start_real, [63:32] start_imag
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [15:0] iteration_count
);

  // Configuration registers
  jet_pkg::word_t  c_real_q, c_imag_q;
  jet_pkg::limit_t limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= jet_pkg::C_REAL_RESET;
      c_imag_q <= jet_pkg::C_IMAG_RESET;
      limit_q  <= jet_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        jet_pkg::CFG_C_REAL: c_real_q <= cfg_data_i;
        jet_pkg::CFG_C_IMAG: c_imag_q <= cfg_data_i;
        jet_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i[jet_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  jet_pkg::count_t limit_eff;
  assign limit_eff = jet_pkg::clamp_limit(limit_q);

  // Handshake and ring control
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  jet_pkg::count_t out_count_q;
  logic in_accept, res_any, res_load, ring_en;
  jet_pkg::count_t res_count;

  jet_pkg::token_t  ring_tok [jet_pkg::NUM_CELLS];
  jet_pkg::result_t ring_res [jet_pkg::NUM_CELLS];
  jet_pkg::token_t  inject_tok;

  assign s_axis_tready = !busy_q;
  assign in_accept     = s_axis_tvalid && !busy_q;

  // Collect the one finished result from the ring
  always_comb begin
    res_any   = 1'b0;
    res_count = '0;
    for (int k = 0; k < jet_pkg::NUM_CELLS; k++) begin
      res_any   = res_any | ring_res[k].valid;
      res_count = res_count | (ring_res[k].count & {jet_pkg::COUNT_WIDTH{ring_res[k].valid}});
    end
  end

  assign res_load = res_any && (!out_valid_q || m_axis_tready);
  assign ring_en  = !res_any || res_load;

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (res_load) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
    end
    if (in_accept) busy_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_count_q <= res_count;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_count_q);

  // New pixel enters cell 0, otherwise the ring closes on itself
  always_comb begin
    if (in_accept) begin
      inject_tok.valid = 1'b1;
      inject_tok.zr    = s_axis_tdata[31:0];
      inject_tok.zi    = s_axis_tdata[63:32];
      inject_tok.count = '0;
    end else begin
      inject_tok = ring_tok[jet_pkg::NUM_CELLS-1];
    end
  end

  // Cell ring
  for (genvar k = 0; k < jet_pkg::NUM_CELLS; k++) begin : g_cell
    jet_pkg::token_t cell_tok;

    if (k == 0) begin : g_head
      assign cell_tok = inject_tok;
    end else begin : g_link
      assign cell_tok = ring_tok[k-1];
    end

    jet_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (ring_en),
      .c_real_i (c_real_q),
      .c_imag_i (c_imag_q),
      .limit_i  (limit_eff),
      .tok_i    (cell_tok),
      .tok_o    (ring_tok[k]),
      .res_o    (ring_res[k])
    );
  end

endmodule

@@ sv/jet_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_checker
// Port-level checks of the escape-time unit, bound to the top level.
// ----------------------------------------------------------------------------
module jet_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic [jet_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input logic [jet_pkg::WORD_WIDTH-1:0]      cfg_data_i,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [15:0]                         m_axis_tdata
);

  // Shadow of the limit register as seen on the write port
  jet_pkg::limit_t lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= jet_pkg::LIMIT_RESET;
    end else if (cfg_we_i && (cfg_index_i == jet_pkg::CFG_LIMIT)) begin
      lim_q <= cfg_data_i[jet_pkg::LIMIT_WIDTH-1:0];
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An accepted pixel drops the input ready right after its transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // A result only appears while a pixel was in flight
  a_result_needs_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a pixel in flight");

  // Count never exceeds the programmed limit
  a_count_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata <= lim_q))
    else $error("iteration count above limit");

endmodule

bind julia_escape_time_unit jet_checker u_jet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Julia escape-time unit. A directed table covers
// register extremes, points outside at start, zero and full limits, ignored
// register writes and saturation of z. Random pixels under four idle and
// stall patterns follow. Every count is checked against a fixed-point
// predictor of the iteration or against the hand-typed count of its row.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int BLOCK_PIXELS   = 100;

  // Register index that maps to no register
  localparam logic [jet_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

  // Q4.28 values used by the directed table
  localparam logic [31:0] Q_ZERO    = 32'h0000_0000;
  localparam logic [31:0] Q_LSB     = 32'h0000_0001;
  localparam logic [31:0] Q_NEG_LSB = 32'hFFFF_FFFF;
  localparam logic [31:0] Q_HALF    = 32'h0800_0000;
  localparam logic [31:0] Q_NHALF   = 32'hF800_0000;
  localparam logic [31:0] Q_ONE     = 32'h1000_0000;
  localparam logic [31:0] Q_NONE    = 32'hF000_0000;
  localparam logic [31:0] Q_1P4     = 32'h1666_6666;
  localparam logic [31:0] Q_N1P4    = 32'hE999_999A;
  localparam logic [31:0] Q_1P9     = 32'h1E66_6666;
  localparam logic [31:0] Q_TWO     = 32'h2000_0000;
  localparam logic [31:0] Q_NTWO    = 32'hE000_0000;
  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;

  // Classic c = -0.8 + 0.156i
  localparam jet_pkg::word_t C_PRESET_RE = -32'sd214748365;
  localparam jet_pkg::word_t C_PRESET_IM = 32'sd41875931;

  // Half-widths of the random spans
  localparam int unsigned SPAN_TWO  = 32'h2000_0000;
  localparam int unsigned SPAN_ONE  = 32'h1000_0000;
  localparam int unsigned SPAN_HALF = 32'h0800_0000;

  localparam longint SAT_HI     = 64'sd2147483647;
  localparam longint SAT_LO     = -64'sd2147483648;
  localparam longint ESCAPE_SUM = 64'sd4 <<< jet_pkg::FRACTION_BITS;

  typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_e;

  // Directed row: a register write (index, data) or a pixel (re, im),
  // with an optional hand-typed count
  typedef struct packed {
    row_kind_e                           kind;
    logic [jet_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [31:0]                         a;
    logic [31:0]                         b;
    logic                                fixed;
    jet_pkg::count_t                     want;
  } dir_row_t;

  localparam int DIR_ROW_COUNT = 38;

  // Index field is unused on pixel rows
  dir_row_t dir_rows [DIR_ROW_COUNT] = '{
    // reset registers: c = 0.37 + 0.1i, limit 500
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_MAX,     Q_MAX,     1'b1, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_MIN,     Q_MIN,     1'b1, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_MIN,     Q_ZERO,    1'b1, 16'd0},
    // magnitude exactly 4.0 is not an escape
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_TWO,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_NTWO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_TWO,     Q_LSB,     1'b0, 16'd0},
    // negative products round toward minus infinity
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_NEG_LSB, Q_LSB,     1'b0, 16'd0},
    // limit of zero
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'd0,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b1, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_MAX,     Q_ZERO,    1'b1, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'd1,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b1, 16'd1},
    // c = 0 with the full limit: origin never escapes
    '{ROW_WRITE, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_C_IMAG, Q_ZERO,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'h0000_FFFF, Q_ZERO, 1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b1, 16'd65535},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_MIN,     Q_MAX,     1'b1, 16'd0},
    // upper data bits of a limit write are dropped
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'hABCD_0003, Q_ZERO, 1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b1, 16'd3},
    // write to an unmapped index leaves the limit alone
    '{ROW_WRITE, CFG_UNUSED,          32'd1,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ONE,     Q_ZERO,    1'b1, 16'd3},
    // extreme c: real and imaginary parts saturate
    '{ROW_WRITE, jet_pkg::CFG_C_REAL, Q_MAX,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_C_IMAG, Q_MIN,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'd20,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_1P9,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_1P4,     Q_N1P4,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_C_REAL, Q_MIN,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_C_IMAG, Q_MAX,     Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_1P9,     1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_1P4,     Q_1P4,     1'b0, 16'd0},
    // classic preset, default limit
    '{ROW_WRITE, jet_pkg::CFG_C_REAL, C_PRESET_RE, Q_ZERO,  1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_C_IMAG, C_PRESET_IM, Q_ZERO,  1'b0, 16'd0},
    '{ROW_WRITE, jet_pkg::CFG_LIMIT,  32'd500,   Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_ZERO,    Q_ZERO,    1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_HALF,    Q_NHALF,   1'b0, 16'd0},
    '{ROW_POINT, jet_pkg::CFG_C_REAL, Q_NONE,    Q_HALF,    1'b0, 16'd0}
  };

  logic                                clk_i = 1'b0;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [jet_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i;
  logic [jet_pkg::WORD_WIDTH-1:0]      cfg_data_i;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [63:0]                         s_axis_tdata;   // [31:0] start_real, [63:32] start_imag
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [15:0]                         m_axis_tdata;   // [15:0] iteration_count

  // Shadow of the c and limit registers
  jet_pkg::word_t  pred_c_re;
  jet_pkg::word_t  pred_c_im;
  jet_pkg::limit_t pred_limit;

  jet_pkg::count_t pending_counts [$];
  jet_pkg::count_t want_count;
  int              err_count = 0;
  int unsigned     cycle_count = 0;
  int              send_idle_pct;
  int              recv_stall_pct;

  julia_escape_time_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Clamp to the signed 32-bit range
  function automatic longint clamp_word(input longint x);
    if (x > SAT_HI) begin
      return SAT_HI;
    end else if (x < SAT_LO) begin
      return SAT_LO;
    end
    return x;
  endfunction

  // Iterations of z = z*z + c before |z|^2 > 4 or the limit
  function automatic jet_pkg::count_t escape_count(input jet_pkg::word_t start_re,
                                                   input jet_pkg::word_t start_im);
    longint zr;
    longint zi;
    longint nr;
    longint rr;
    longint ii;
    longint lim;
    longint n;
    zr  = longint'(start_re);
    zi  = longint'(start_im);
    lim = longint'(pred_limit);
    if (lim > longint'(jet_pkg::COUNT_MAX)) begin
      lim = longint'(jet_pkg::COUNT_MAX);
    end
    n  = 0;
    rr = (zr * zr) >>> jet_pkg::FRACTION_BITS;
    ii = (zi * zi) >>> jet_pkg::FRACTION_BITS;
    while (n < lim && rr + ii <= ESCAPE_SUM) begin
      nr = clamp_word(rr - ii + longint'(pred_c_re));
      // 2*r*i: one fraction bit less in the shift
      zi = clamp_word(((zr * zi) >>> (jet_pkg::FRACTION_BITS - 1)) + longint'(pred_c_im));
      zr = nr;
      rr = (zr * zr) >>> jet_pkg::FRACTION_BITS;
      ii = (zi * zi) >>> jet_pkg::FRACTION_BITS;
      n++;
    end
    return jet_pkg::count_t'(n);
  endfunction

  // Uniform value in [-half, half]
  function automatic jet_pkg::word_t rand_span(input int unsigned half);
    return jet_pkg::word_t'(int'($urandom_range(0, 2 * half)) - int'(half));
  endfunction

  // Mostly points within 2 of the origin per coordinate, some near the origin, some full range
  function automatic jet_pkg::word_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      return jet_pkg::word_t'($urandom);
    end else if (pick < 75) begin
      return rand_span(SPAN_TWO);
    end
    return rand_span(SPAN_HALF);
  endfunction

  // Register write; the shadow follows at the write edge
  task automatic write_reg(input logic [jet_pkg::CFG_INDEX_WIDTH-1:0] index,
                           input logic [jet_pkg::WORD_WIDTH-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    unique case (index)
      jet_pkg::CFG_C_REAL: pred_c_re = jet_pkg::word_t'(data);
      jet_pkg::CFG_C_IMAG: pred_c_im = jet_pkg::word_t'(data);
      jet_pkg::CFG_LIMIT:  pred_limit = data[jet_pkg::LIMIT_WIDTH-1:0];
      default: ;  // unmapped index: ignored
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One start-point transaction; expected count queued on acceptance
  task automatic send_point(input jet_pkg::word_t re, input jet_pkg::word_t im,
                            input logic fixed, input jet_pkg::count_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {im, re};
    do @(posedge clk_i); while (!s_axis_tready);
    if (fixed) begin
      pending_counts.push_back(want);
    end else begin
      pending_counts.push_back(escape_count(re, im));
    end
  endtask

  task automatic wait_idle();
    while (pending_counts.size() != 0) @(posedge clk_i);
  endtask

  // Compare each result transaction with the oldest expected count
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        err_count++;
        if (err_count <= 10) begin
          $display("ERROR: count %0d arrived with no pixel pending", m_axis_tdata);
        end
      end else begin
        want_count = pending_counts.pop_front();
        if (m_axis_tdata !== want_count) begin
          err_count++;
          if (err_count <= 10) begin
            $display("ERROR: iteration count expected %0d, got %0d",
                     want_count, m_axis_tdata);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int              phase;
    int              blk;
    jet_pkg::word_t  c_re;
    jet_pkg::word_t  c_im;
    jet_pkg::limit_t lim;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = jet_pkg::CFG_C_REAL;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pred_c_re      = 32'sd99321119;
    pred_c_im      = 32'sd26843546;
    pred_limit     = 16'd500;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_WRITE) begin
        s_axis_tvalid <= 1'b0;
        wait_idle();
        write_reg(dir_rows[k].index, dir_rows[k].a);
      end else begin
        send_point(dir_rows[k].a, dir_rows[k].b, dir_rows[k].fixed, dir_rows[k].want);
      end
    end
    s_axis_tvalid <= 1'b0;

    // Random pixels: four idle patterns, three register settings each
    for (phase = 0; phase < 4; phase++) begin
      unique case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int b = 0; b < 3; b++) begin
        blk = phase * 3 + b;
        // registers change only with the ring drained
        wait_idle();
        unique case (blk % 4)
          0: begin c_re = C_PRESET_RE;         c_im = C_PRESET_IM;         end
          1: begin c_re = rand_span(SPAN_ONE); c_im = rand_span(SPAN_ONE); end
          2: begin c_re = rand_span(SPAN_TWO); c_im = rand_span(SPAN_TWO); end
          default: begin
            c_re = jet_pkg::word_t'($urandom);
            c_im = jet_pkg::word_t'($urandom);
          end
        endcase
        lim = (blk == 5) ? jet_pkg::limit_t'(500) : jet_pkg::limit_t'($urandom_range(2, 64));
        write_reg(jet_pkg::CFG_C_REAL, c_re);
        write_reg(jet_pkg::CFG_C_IMAG, c_im);
        write_reg(jet_pkg::CFG_LIMIT, {16'($urandom), lim});
        for (int k = 0; k < BLOCK_PIXELS; k++) begin
          send_point(rand_coord(), rand_coord(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
